// File: src/asfe_pkg.sv
// ----------------------------------------------------------------------------
// asfe_pkg
// Shared constants, codes and saturating helpers of the Akima spline engine.
// ----------------------------------------------------------------------------
package asfe_pkg;

    localparam int MAX_POINTS = 64;
    localparam int FRAC_BITS  = 16;
    localparam int CF         = 2 * FRAC_BITS;
    localparam int AW         = $clog2(MAX_POINTS);
    localparam int CW         = $clog2(MAX_POINTS + 1);
    localparam int MIN_FIT    = 4;
    localparam int KW         = 64;
    localparam int BW         = 192;

    localparam logic signed [63:0] MAX64 = {1'b0, {63{1'b1}}};
    localparam logic signed [63:0] MIN64 = {1'b1, {63{1'b0}}};
    localparam logic signed [63:0] MAX32 = 64'sh0000_0000_7fff_ffff;
    localparam logic signed [63:0] MIN32 = -64'sh0000_0000_8000_0000;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_EVAL = 1'b1;

    typedef enum logic [2:0] {
        ST_STORED = 3'd0,
        ST_FIT    = 3'd1,
        ST_VALUE  = 3'd2,
        ST_NOFIT  = 3'd3,
        ST_FULL   = 3'd4
    } t_status;

    function automatic logic signed [63:0] sat64(input logic signed [127:0] a);
        logic signed [63:0] r;
        if (a[127:63] == '0 || a[127:63] == '1) begin
            r = a[63:0];
        end else if (a[127]) begin
            r = MIN64;
        end else begin
            r = MAX64;
        end
        return r;
    endfunction

    function automatic logic signed [63:0] twice_minus(input logic signed [63:0] a,
                                                       input logic signed [63:0] b);
        return sat64(128'(a) + 128'(a) - 128'(b));
    endfunction

    function automatic logic signed [63:0] abs_diff(input logic signed [63:0] a,
                                                    input logic signed [63:0] b);
        logic signed [127:0] d;
        d = 128'(a) - 128'(b);
        return sat64(d[127] ? -d : d);
    endfunction

endpackage

// File: src/asfe_ram.sv
// ----------------------------------------------------------------------------
// asfe_ram
// Single-port synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module asfe_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: src/asfe_mul.sv
// ----------------------------------------------------------------------------
// asfe_mul
// Signed 64x64 multiplier, one 32x32 partial product per cycle.
// ----------------------------------------------------------------------------
module asfe_mul (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic signed [63:0]   i_a,
    input  logic signed [63:0]   i_b,
    output logic                 o_done,
    output logic signed [127:0]  o_prod
);

    logic          r_busy, n_busy;
    logic          r_fin, n_fin;
    logic          r_done, n_done;
    logic [1:0]    r_step, n_step;
    logic [63:0]   r_ua, n_ua;
    logic [63:0]   r_ub, n_ub;
    logic          r_neg, n_neg;
    logic [127:0]  r_acc, n_acc;
    logic [127:0]  r_prod, n_prod;

    always_comb begin
        logic [31:0]  pa;
        logic [31:0]  pb;
        logic [63:0]  pp;
        logic [127:0] sh;
        n_busy = r_busy;
        n_fin  = 1'b0;
        n_done = 1'b0;
        n_step = r_step;
        n_ua   = r_ua;
        n_ub   = r_ub;
        n_neg  = r_neg;
        n_acc  = r_acc;
        n_prod = r_prod;
        pa = r_step[1] ? r_ua[63:32] : r_ua[31:0];
        pb = r_step[0] ? r_ub[63:32] : r_ub[31:0];
        pp = 64'(pa) * 64'(pb);
        case ({r_step[1], r_step[0]} == 2'b11 ? 2'd2 : (r_step == 2'b00 ? 2'd0 : 2'd1))
            2'd0:    sh = 128'(pp);
            2'd1:    sh = 128'(pp) << 32;
            2'd2:    sh = 128'(pp) << 64;
            default: sh = 128'(pp);
        endcase
        if (i_start) begin
            n_ua   = i_a[63] ? 64'(-i_a) : 64'(i_a);
            n_ub   = i_b[63] ? 64'(-i_b) : 64'(i_b);
            n_neg  = i_a[63] ^ i_b[63];
            n_acc  = '0;
            n_step = '0;
            n_busy = 1'b1;
        end else if (r_busy) begin
            n_acc  = r_acc + sh;
            n_step = r_step + 2'd1;
            if (r_step == 2'd3) begin
                n_busy = 1'b0;
                n_fin  = 1'b1;
            end
        end
        if (r_fin) begin
            n_prod = r_neg ? -r_acc : r_acc;
            n_done = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fin  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_fin  <= n_fin;
            r_done <= n_done;
        end
        r_step <= n_step;
        r_ua   <= n_ua;
        r_ub   <= n_ub;
        r_neg  <= n_neg;
        r_acc  <= n_acc;
        r_prod <= n_prod;
    end

    assign o_done = r_done;
    assign o_prod = r_prod;

endmodule

// File: src/asfe_div.sv
// ----------------------------------------------------------------------------
// asfe_div
// Signed 128/64 truncating divider, one quotient bit per cycle, saturated.
// ----------------------------------------------------------------------------
module asfe_div (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic signed [127:0]  i_num,
    input  logic signed [63:0]   i_den,
    output logic                 o_done,
    output logic signed [63:0]   o_quot
);

    logic          r_busy, n_busy;
    logic          r_fin, n_fin;
    logic          r_done, n_done;
    logic [6:0]    r_cnt, n_cnt;
    logic [127:0]  r_sh, n_sh;
    logic [63:0]   r_rem, n_rem;
    logic [63:0]   r_ud, n_ud;
    logic          r_neg, n_neg;
    logic [63:0]   r_quot, n_quot;

    always_comb begin
        logic [64:0]  rem_s;
        logic         ge;
        logic [127:0] q;
        n_busy = r_busy;
        n_fin  = 1'b0;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_sh   = r_sh;
        n_rem  = r_rem;
        n_ud   = r_ud;
        n_neg  = r_neg;
        n_quot = r_quot;
        rem_s  = {r_rem, r_sh[127]};
        ge     = rem_s >= {1'b0, r_ud};
        q      = r_neg ? -r_sh : r_sh;
        if (i_start) begin
            if (i_den == '0) begin
                n_quot = '0;
                n_done = 1'b1;
            end else begin
                n_sh   = i_num[127] ? 128'(-i_num) : 128'(i_num);
                n_ud   = i_den[63] ? 64'(-i_den) : 64'(i_den);
                n_neg  = i_num[127] ^ i_den[63];
                n_rem  = '0;
                n_cnt  = '0;
                n_busy = 1'b1;
            end
        end else if (r_busy) begin
            n_rem = ge ? 64'(rem_s - {1'b0, r_ud}) : rem_s[63:0];
            n_sh  = {r_sh[126:0], ge};
            n_cnt = r_cnt + 7'd1;
            if (r_cnt == 7'd127) begin
                n_busy = 1'b0;
                n_fin  = 1'b1;
            end
        end
        if (r_fin) begin
            n_quot = asfe_pkg::sat64(q);
            n_done = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fin  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_fin  <= n_fin;
            r_done <= n_done;
        end
        r_cnt  <= n_cnt;
        r_sh   <= n_sh;
        r_rem  <= n_rem;
        r_ud   <= n_ud;
        r_neg  <= n_neg;
        r_quot <= n_quot;
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

// File: src/akima_spline_fit_and_eval_core.sv
// ----------------------------------------------------------------------------
// akima_spline_fit_and_eval_core
// Akima spline engine: breakpoint table, coefficient fit and evaluation.
// ----------------------------------------------------------------------------
// Input channel (i_valid/o_ready) carries one word per load or query. The
// output channel (o_valid/i_ready) returns one word per input word.
// A load stores a breakpoint into the knot RAM unless the table is full; its
// answer passes through the result and output registers. A load marked last
// with at least four points stored runs the fit, one interval at a time:
// each interval costs three to five passes of the divider plus none or two
// multiplies. A query reads the knot RAM for up to six binary search steps,
// then the coefficient RAM, and runs three multiplies through the shared
// multiplier. Work is one word at a time; the divider sets the fit time, the
// knot RAM port and the multiplier the query time.
// Reset empties the table and drops the fit; RAM contents are not cleared.
// A result waits in the output register while the receiver stalls; the next
// word is accepted meanwhile and its result holds until that one is taken.
// ----------------------------------------------------------------------------
module akima_spline_fit_and_eval_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic               i_op,
    input  logic signed [31:0] i_sample_x,
    input  logic signed [31:0] i_sample_y,
    input  logic               i_last_sample,
    input  logic signed [31:0] i_query_x,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [31:0] o_value,
    output logic [5:0]         o_segment,
    output logic [2:0]         o_status
);

    localparam int AW  = asfe_pkg::AW;
    localparam int CW  = asfe_pkg::CW;
    localparam int NST = 39;

    typedef enum logic [NST-1:0] {
        S_IDLE = NST'(1) << 0,  S_OUT  = NST'(1) << 1,  S_UW   = NST'(1) << 2,
        S_SL0  = NST'(1) << 3,  S_SL1  = NST'(1) << 4,  S_SL2  = NST'(1) << 5,
        S_SL3  = NST'(1) << 6,  S_TG0  = NST'(1) << 7,  S_TG1  = NST'(1) << 8,
        S_TG2  = NST'(1) << 9,  S_TG3  = NST'(1) << 10, S_FI0  = NST'(1) << 11,
        S_FI1  = NST'(1) << 12, S_FI2  = NST'(1) << 13, S_FI3  = NST'(1) << 14,
        S_FI4  = NST'(1) << 15, S_FI5  = NST'(1) << 16, S_FI6  = NST'(1) << 17,
        S_FL0  = NST'(1) << 18, S_FH1  = NST'(1) << 19, S_FH2  = NST'(1) << 20,
        S_FL2  = NST'(1) << 21, S_FL3  = NST'(1) << 22, S_FL4  = NST'(1) << 23,
        S_FL5  = NST'(1) << 24, S_FL6  = NST'(1) << 25, S_FL7  = NST'(1) << 26,
        S_FL8  = NST'(1) << 27, S_FEND = NST'(1) << 28, S_Q0   = NST'(1) << 29,
        S_Q1   = NST'(1) << 30, S_Q2   = NST'(1) << 31, S_QS0  = NST'(1) << 32,
        S_QS1  = NST'(1) << 33, S_QF0  = NST'(1) << 34, S_QF1  = NST'(1) << 35,
        S_QH1  = NST'(1) << 36, S_QH2  = NST'(1) << 37, S_QH3  = NST'(1) << 38
    } t_state;

    t_state r_state, n_state;
    t_state r_ret_unit, n_ret_unit;
    t_state r_ret_sub, n_ret_sub;

    logic [CW-1:0]      r_cnt, n_cnt;
    logic               r_fit, n_fit;
    logic               r_ov, n_ov;
    logic signed [31:0] r_oval, n_oval;
    logic [5:0]         r_oseg, n_oseg;
    asfe_pkg::t_status  r_ost, n_ost;
    logic signed [31:0] r_rval, n_rval;
    logic [5:0]         r_rseg, n_rseg;
    asfe_pkg::t_status  r_rst, n_rst;

    logic signed [31:0] r_qx, n_qx;
    logic [CW-1:0]      r_fi, n_fi;
    logic [AW-1:0]      r_sidx, n_sidx;
    logic signed [31:0] r_k0x, n_k0x;
    logic signed [31:0] r_k0y, n_k0y;
    logic signed [63:0] r_h, n_h;
    logic signed [63:0] r_m2, n_m2;
    logic signed [63:0] r_m3, n_m3;
    logic signed [63:0] r_m4, n_m4;
    logic signed [63:0] r_m5, n_m5;
    logic signed [63:0] r_m54, n_m54;
    logic signed [63:0] r_m43, n_m43;
    logic signed [63:0] r_m32, n_m32;
    logic signed [63:0] r_m21, n_m21;
    logic signed [63:0] r_t1, n_t1;
    logic signed [63:0] r_t2, n_t2;
    logic signed [63:0] r_wa, n_wa;
    logic signed [63:0] r_ma, n_ma;
    logic signed [63:0] r_wb, n_wb;
    logic signed [63:0] r_mb, n_mb;
    logic signed [63:0] r_den, n_den;
    logic signed [63:0] r_res, n_res;
    logic signed [127:0] r_p, n_p;
    logic signed [63:0] r_cn, n_cn;
    logic signed [63:0] r_dn, n_dn;
    logic signed [63:0] r_cc, n_cc;
    logic [CW-1:0]      r_lo, n_lo;
    logic [CW-1:0]      r_hi, n_hi;
    logic [CW-1:0]      r_mid, n_mid;
    logic [AW-1:0]      r_i, n_i;
    logic signed [31:0] r_ky, n_ky;
    logic signed [32:0] r_z, n_z;
    logic signed [63:0] r_b, n_b;
    logic signed [63:0] r_c, n_c;

    logic                         k_we;
    logic [AW-1:0]                k_addr;
    logic [asfe_pkg::KW-1:0]      k_wd, k_q;
    logic                         c_we;
    logic [AW-1:0]                c_addr;
    logic [asfe_pkg::BW-1:0]      c_wd, c_q;

    logic                m_start, m_done;
    logic signed [63:0]  m_a, m_b;
    logic signed [127:0] m_prod;
    logic                d_start, d_done;
    logic signed [127:0] d_num;
    logic signed [63:0]  d_den, d_quot;

    logic accept;

    asfe_ram #(.WIDTH(asfe_pkg::KW), .DEPTH(asfe_pkg::MAX_POINTS)) u_knot_ram (
        .i_clk   (i_clk),
        .i_we    (k_we),
        .i_addr  (k_addr),
        .i_wdata (k_wd),
        .o_rdata (k_q)
    );

    asfe_ram #(.WIDTH(asfe_pkg::BW), .DEPTH(asfe_pkg::MAX_POINTS)) u_coef_ram (
        .i_clk   (i_clk),
        .i_we    (c_we),
        .i_addr  (c_addr),
        .i_wdata (c_wd),
        .o_rdata (c_q)
    );

    asfe_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (m_start),
        .i_a     (m_a),
        .i_b     (m_b),
        .o_done  (m_done),
        .o_prod  (m_prod)
    );

    asfe_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (d_start),
        .i_num   (d_num),
        .i_den   (d_den),
        .o_done  (d_done),
        .o_quot  (d_quot)
    );

    assign o_ready = (r_state == S_IDLE);
    assign accept  = i_valid & o_ready;

    always_comb begin
        logic [CW-1:0]       cnt_e;
        logic signed [31:0]  qkx;
        logic signed [31:0]  qky;
        logic signed [32:0]  dy;
        logic signed [32:0]  dx;
        logic signed [32:0]  zz;
        logic signed [63:0]  m1;
        logic signed [63:0]  tt;
        logic signed [63:0]  dsum;
        logic [CW:0]         sum_lh;

        n_state    = r_state;
        n_ret_unit = r_ret_unit;
        n_ret_sub  = r_ret_sub;
        n_cnt  = r_cnt;
        n_fit  = r_fit;
        n_ov   = r_ov & ~i_ready;
        n_oval = r_oval;
        n_oseg = r_oseg;
        n_ost  = r_ost;
        n_rval = r_rval;
        n_rseg = r_rseg;
        n_rst  = r_rst;
        n_qx   = r_qx;
        n_fi   = r_fi;
        n_sidx = r_sidx;
        n_k0x  = r_k0x;
        n_k0y  = r_k0y;
        n_h    = r_h;
        n_m2   = r_m2;
        n_m3   = r_m3;
        n_m4   = r_m4;
        n_m5   = r_m5;
        n_m54  = r_m54;
        n_m43  = r_m43;
        n_m32  = r_m32;
        n_m21  = r_m21;
        n_t1   = r_t1;
        n_t2   = r_t2;
        n_wa   = r_wa;
        n_ma   = r_ma;
        n_wb   = r_wb;
        n_mb   = r_mb;
        n_den  = r_den;
        n_res  = r_res;
        n_p    = r_p;
        n_cn   = r_cn;
        n_dn   = r_dn;
        n_cc   = r_cc;
        n_lo   = r_lo;
        n_hi   = r_hi;
        n_mid  = r_mid;
        n_i    = r_i;
        n_ky   = r_ky;
        n_z    = r_z;
        n_b    = r_b;
        n_c    = r_c;

        k_we   = 1'b0;
        k_addr = '0;
        k_wd   = {i_sample_x, i_sample_y};
        c_we   = 1'b0;
        c_addr = r_fi[AW-1:0];
        c_wd   = '0;
        m_start = 1'b0;
        m_a     = '0;
        m_b     = '0;
        d_start = 1'b0;
        d_num   = '0;
        d_den   = r_h;

        cnt_e  = r_fit ? '0 : r_cnt;
        qkx    = $signed(k_q[63:32]);
        qky    = $signed(k_q[31:0]);
        dy     = 33'(qky) - 33'(r_k0y);
        dx     = 33'(qkx) - 33'(r_k0x);
        zz     = 33'(r_qx) - 33'(qkx);
        m1     = asfe_pkg::twice_minus(r_m2, r_m3);
        tt     = '0;
        dsum   = asfe_pkg::sat64(128'(r_wa) + 128'(r_wb));
        sum_lh = {1'b0, r_lo} + {1'b0, r_hi};

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_rval = '0;
                    n_rseg = '0;
                    if (i_op == asfe_pkg::OP_LOAD) begin
                        n_fit = 1'b0;
                        n_cnt = cnt_e;
                        n_state = S_OUT;
                        if (cnt_e >= CW'(asfe_pkg::MAX_POINTS)) begin
                            n_rst = asfe_pkg::ST_FULL;
                        end else begin
                            k_we   = 1'b1;
                            k_addr = cnt_e[AW-1:0];
                            n_cnt  = cnt_e + CW'(1);
                            n_rst  = asfe_pkg::ST_STORED;
                            if (i_last_sample) begin
                                if (cnt_e + CW'(1) >= CW'(asfe_pkg::MIN_FIT)) begin
                                    n_state = S_FI0;
                                end else begin
                                    n_cnt = '0;
                                    n_rst = asfe_pkg::ST_NOFIT;
                                end
                            end
                        end
                    end else if (!r_fit) begin
                        n_rst   = asfe_pkg::ST_NOFIT;
                        n_state = S_OUT;
                    end else begin
                        n_qx    = i_query_x;
                        n_state = S_Q0;
                    end
                end
            end
            S_OUT: begin
                if (!r_ov || i_ready) begin
                    n_ov    = 1'b1;
                    n_oval  = r_rval;
                    n_oseg  = r_rseg;
                    n_ost   = r_rst;
                    n_state = S_IDLE;
                end
            end
            S_UW: begin
                if (m_done || d_done) begin
                    n_state = r_ret_unit;
                end
            end
            S_SL0: begin
                k_addr  = r_sidx;
                n_state = S_SL1;
            end
            S_SL1: begin
                k_addr  = r_sidx + AW'(1);
                n_k0x   = qkx;
                n_k0y   = qky;
                n_state = S_SL2;
            end
            S_SL2: begin
                d_start    = 1'b1;
                d_num      = 128'(dy) <<< asfe_pkg::CF;
                d_den      = 64'(dx);
                n_ret_unit = S_SL3;
                n_state    = S_UW;
            end
            S_SL3: begin
                n_res   = d_quot;
                n_state = r_ret_sub;
            end
            S_TG0: begin
                n_den = dsum;
                if (dsum == '0) begin
                    n_res   = asfe_pkg::sat64((128'(r_ma) + 128'(r_mb)) >>> 1);
                    n_state = r_ret_sub;
                end else begin
                    m_start    = 1'b1;
                    m_a        = r_wa;
                    m_b        = r_ma;
                    n_ret_unit = S_TG1;
                    n_state    = S_UW;
                end
            end
            S_TG1: begin
                n_p        = m_prod;
                m_start    = 1'b1;
                m_a        = r_wb;
                m_b        = r_mb;
                n_ret_unit = S_TG2;
                n_state    = S_UW;
            end
            S_TG2: begin
                d_start    = 1'b1;
                d_num      = r_p + m_prod;
                d_den      = r_den;
                n_ret_unit = S_TG3;
                n_state    = S_UW;
            end
            S_TG3: begin
                n_res   = d_quot;
                n_state = r_ret_sub;
            end
            S_FI0: begin
                n_sidx    = AW'(0);
                n_ret_sub = S_FI1;
                n_state   = S_SL0;
            end
            S_FI1: begin
                n_m3      = r_res;
                n_sidx    = AW'(1);
                n_ret_sub = S_FI2;
                n_state   = S_SL0;
            end
            S_FI2: begin
                n_m4      = r_res;
                n_sidx    = AW'(2);
                n_ret_sub = S_FI3;
                n_state   = S_SL0;
            end
            S_FI3: begin
                n_m5    = r_res;
                n_m2    = asfe_pkg::twice_minus(r_m3, r_m4);
                n_m54   = asfe_pkg::abs_diff(r_res, r_m4);
                n_m43   = asfe_pkg::abs_diff(r_m4, r_m3);
                n_state = S_FI4;
            end
            S_FI4: begin
                n_m32   = asfe_pkg::abs_diff(r_m3, r_m2);
                n_m21   = asfe_pkg::abs_diff(r_m2, m1);
                n_state = S_FI5;
            end
            S_FI5: begin
                n_wa      = r_m43;
                n_ma      = r_m2;
                n_wb      = r_m21;
                n_mb      = r_m3;
                n_ret_sub = S_FI6;
                n_state   = S_TG0;
            end
            S_FI6: begin
                n_t1    = r_res;
                n_fi    = '0;
                n_state = S_FL0;
            end
            S_FL0: begin
                if ({1'b0, r_fi} + (CW+1)'(1) >= {1'b0, r_cnt}) begin
                    n_state = S_FEND;
                end else begin
                    k_addr  = r_fi[AW-1:0];
                    n_state = S_FH1;
                end
            end
            S_FH1: begin
                k_addr  = r_fi[AW-1:0] + AW'(1);
                n_k0x   = qkx;
                n_k0y   = qky;
                n_state = S_FH2;
            end
            S_FH2: begin
                n_h       = 64'(dx);
                n_wa      = r_m54;
                n_ma      = r_m3;
                n_wb      = r_m32;
                n_mb      = r_m4;
                n_ret_sub = S_FL2;
                n_state   = S_TG0;
            end
            S_FL2: begin
                n_t2 = r_res;
                n_cn = asfe_pkg::sat64(128'(r_m3) + 128'(r_m3) + 128'(r_m3)
                                       - 128'(r_t1) - 128'(r_t1) - 128'(r_res));
                n_dn = asfe_pkg::sat64(128'(r_t1) + 128'(r_res)
                                       - 128'(r_m3) - 128'(r_m3));
                n_state = S_FL3;
            end
            S_FL3: begin
                d_start    = 1'b1;
                d_num      = 128'(r_cn) <<< asfe_pkg::FRAC_BITS;
                n_ret_unit = S_FL4;
                n_state    = S_UW;
            end
            S_FL4: begin
                n_cc       = d_quot;
                d_start    = 1'b1;
                d_num      = 128'(r_dn) <<< asfe_pkg::FRAC_BITS;
                n_ret_unit = S_FL5;
                n_state    = S_UW;
            end
            S_FL5: begin
                d_start    = 1'b1;
                d_num      = 128'(d_quot) <<< asfe_pkg::FRAC_BITS;
                n_ret_unit = S_FL6;
                n_state    = S_UW;
            end
            S_FL6: begin
                c_we   = 1'b1;
                c_addr = r_fi[AW-1:0];
                c_wd   = {r_t1, r_cc, d_quot};
                n_m3   = r_m4;
                n_m4   = r_m5;
                n_m21  = r_m32;
                n_m32  = r_m43;
                n_m43  = r_m54;
                n_t1   = r_t2;
                if ({1'b0, r_fi} + (CW+1)'(4) < {1'b0, r_cnt}) begin
                    n_sidx    = r_fi[AW-1:0] + AW'(3);
                    n_ret_sub = S_FL7;
                    n_state   = S_SL0;
                end else begin
                    n_m5    = asfe_pkg::twice_minus(r_m5, r_m4);
                    n_state = S_FL8;
                end
            end
            S_FL7: begin
                n_m5    = r_res;
                n_state = S_FL8;
            end
            S_FL8: begin
                n_m54   = asfe_pkg::abs_diff(r_m5, r_m4);
                n_fi    = r_fi + CW'(1);
                n_state = S_FL0;
            end
            S_FEND: begin
                c_we    = 1'b1;
                c_addr  = AW'(r_cnt - CW'(1));
                c_wd    = '0;
                n_fit   = 1'b1;
                n_rst   = asfe_pkg::ST_FIT;
                n_state = S_OUT;
            end
            S_Q0: begin
                k_addr  = '0;
                n_state = S_Q1;
            end
            S_Q1: begin
                k_addr  = AW'(r_cnt - CW'(2));
                n_k0x   = qkx;
                n_state = S_Q2;
            end
            S_Q2: begin
                if (r_qx <= r_k0x) begin
                    n_i     = '0;
                    n_state = S_QF0;
                end else if (r_qx >= qkx) begin
                    n_i     = AW'(r_cnt - CW'(2));
                    n_state = S_QF0;
                end else begin
                    n_lo    = '0;
                    n_hi    = r_cnt;
                    n_state = S_QS0;
                end
            end
            S_QS0: begin
                if (r_hi - r_lo > CW'(1)) begin
                    n_mid   = CW'(sum_lh >> 1);
                    k_addr  = AW'(sum_lh >> 1);
                    n_state = S_QS1;
                end else begin
                    n_i     = r_lo[AW-1:0];
                    n_state = S_QF0;
                end
            end
            S_QS1: begin
                if (r_qx < qkx) begin
                    n_hi = r_mid;
                end else begin
                    n_lo = r_mid;
                end
                n_state = S_QS0;
            end
            S_QF0: begin
                k_addr  = r_i;
                c_addr  = r_i;
                n_state = S_QF1;
            end
            S_QF1: begin
                n_ky       = qky;
                n_z        = zz;
                n_b        = $signed(c_q[191:128]);
                n_c        = $signed(c_q[127:64]);
                m_start    = 1'b1;
                m_a        = $signed(c_q[63:0]);
                m_b        = 64'(zz);
                n_ret_unit = S_QH1;
                n_state    = S_UW;
            end
            S_QH1: begin
                tt         = asfe_pkg::sat64(m_prod >>> asfe_pkg::FRAC_BITS);
                tt         = asfe_pkg::sat64(128'(r_c) + 128'(tt));
                m_start    = 1'b1;
                m_a        = tt;
                m_b        = 64'(r_z);
                n_ret_unit = S_QH2;
                n_state    = S_UW;
            end
            S_QH2: begin
                tt         = asfe_pkg::sat64(m_prod >>> asfe_pkg::FRAC_BITS);
                tt         = asfe_pkg::sat64(128'(r_b) + 128'(tt));
                m_start    = 1'b1;
                m_a        = tt;
                m_b        = 64'(r_z);
                n_ret_unit = S_QH3;
                n_state    = S_UW;
            end
            S_QH3: begin
                tt = asfe_pkg::sat64(m_prod >>> asfe_pkg::CF);
                tt = asfe_pkg::sat64(128'(tt) + 128'(r_ky));
                if (tt > asfe_pkg::MAX32) begin
                    tt = asfe_pkg::MAX32;
                end else if (tt < asfe_pkg::MIN32) begin
                    tt = asfe_pkg::MIN32;
                end
                n_rval  = tt[31:0];
                n_rseg  = 6'(r_i);
                n_rst   = asfe_pkg::ST_VALUE;
                n_state = S_OUT;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_ret_unit <= S_IDLE;
            r_ret_sub  <= S_IDLE;
            r_cnt      <= '0;
            r_fit      <= 1'b0;
            r_ov       <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_ret_unit <= n_ret_unit;
            r_ret_sub  <= n_ret_sub;
            r_cnt      <= n_cnt;
            r_fit      <= n_fit;
            r_ov       <= n_ov;
        end
        r_oval <= n_oval;
        r_oseg <= n_oseg;
        r_ost  <= n_ost;
        r_rval <= n_rval;
        r_rseg <= n_rseg;
        r_rst  <= n_rst;
        r_qx   <= n_qx;
        r_fi   <= n_fi;
        r_sidx <= n_sidx;
        r_k0x  <= n_k0x;
        r_k0y  <= n_k0y;
        r_h    <= n_h;
        r_m2   <= n_m2;
        r_m3   <= n_m3;
        r_m4   <= n_m4;
        r_m5   <= n_m5;
        r_m54  <= n_m54;
        r_m43  <= n_m43;
        r_m32  <= n_m32;
        r_m21  <= n_m21;
        r_t1   <= n_t1;
        r_t2   <= n_t2;
        r_wa   <= n_wa;
        r_ma   <= n_ma;
        r_wb   <= n_wb;
        r_mb   <= n_mb;
        r_den  <= n_den;
        r_res  <= n_res;
        r_p    <= n_p;
        r_cn   <= n_cn;
        r_dn   <= n_dn;
        r_cc   <= n_cc;
        r_lo   <= n_lo;
        r_hi   <= n_hi;
        r_mid  <= n_mid;
        r_i    <= n_i;
        r_ky   <= n_ky;
        r_z    <= n_z;
        r_b    <= n_b;
        r_c    <= n_c;
    end

    assign o_valid   = r_ov;
    assign o_value   = r_oval;
    assign o_segment = r_oseg;
    assign o_status  = r_ost;

endmodule
